FILE: hw/rtl/splat_attribute_decoder_assert.svh
// ----------------------------------------------------------------------------
// Splat attribute decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef SPLAT_ATTRIBUTE_DECODER_ASSERT_SVH
`define SPLAT_ATTRIBUTE_DECODER_ASSERT_SVH

// same-cycle implication
`define SAD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SAD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/sad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splat attribute decoder package
// Widths, stage numbers and types of the splat attribute decode pipeline.
// ----------------------------------------------------------------------------
package sad_pkg;

	localparam int LANES     = 4;
	localparam int TERMS     = 63;
	localparam int MAG_W     = 16;
	localparam int TERM_W    = 41;
	localparam int SUM_W     = 44;
	localparam int PROD_W    = 57;
	localparam int XQ_W      = 44;
	localparam int HALF_W    = 22;
	localparam int RCP_SHIFT = 50;
	localparam int PP_W      = 48;
	localparam int FULL_W    = 96;
	localparam int NUM_W     = 61;
	localparam int DEN_W     = 45;
	localparam int DCMP_W    = 62;
	localparam int QB        = 17;

	localparam int SQ_W      = 33;
	localparam int RT_W      = 25;
	localparam int SRM_W     = 51;
	localparam int RNUM_W    = 38;
	localparam int RCMP_W    = 40;
	localparam int RQB       = 15;

	localparam int EXP_DONE  = 3 * TERMS + 2;
	localparam int DIV_PREP  = EXP_DONE + 1;
	localparam int OUT_STG   = DIV_PREP + QB + 1;
	localparam int RDIV_PREP = RT_W + 2;
	localparam int ROT_DONE  = RDIV_PREP + RQB + 1;

	localparam logic [14:0] ONE_Q14 = 15'd16384;
	localparam logic signed [24:0] C0_Q24 = 25'sd4732765;

	typedef struct packed {
		logic [3:0]        neg;
		logic [3:0][15:0]  mag;
		logic              dflt;
	} rot_side_t;

	typedef struct packed {
		logic [14:0]        w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               dflt;
	} rot_res_t;

endpackage

FILE: hw/rtl/splat_attribute_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splat attribute decoder
// Decodes one Gaussian splat record per cycle: unit quaternion, exp scales,
// DC colour and sigmoid opacity.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_stall | rot_w..rot_z, log_scale_*, dc_*, opacity
//   out     | out_valid/out_stall | unit_*, scale_*, color_*, alpha, flag
//
// One item per cycle while the output is not stalled.
// Latency is set by the exp series: 63 Taylor terms at three stages each,
// followed by a 17-stage restoring divider.
// Reset clears only the valid bits.
// A stalled output item freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
`include "splat_attribute_decoder_assert.svh"

module splat_attribute_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] rot_w,
	input  logic signed [15:0] rot_x,
	input  logic signed [15:0] rot_y,
	input  logic signed [15:0] rot_z,
	input  logic signed [15:0] log_scale_x,
	input  logic signed [15:0] log_scale_y,
	input  logic signed [15:0] log_scale_z,
	input  logic signed [15:0] dc_red,
	input  logic signed [15:0] dc_green,
	input  logic signed [15:0] dc_blue,
	input  logic signed [15:0] opacity_logit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [14:0]        unit_w,
	output logic signed [15:0] unit_x,
	output logic signed [15:0] unit_y,
	output logic signed [15:0] unit_z,
	output logic [31:0]        scale_x,
	output logic [31:0]        scale_y,
	output logic [31:0]        scale_z,
	output logic signed [15:0] color_red,
	output logic signed [15:0] color_green,
	output logic signed [15:0] color_blue,
	output logic [15:0]        alpha,
	output logic               rotation_defaulted
);
	import sad_pkg::*;

	logic adv;
	logic [OUT_STG:1] vld_s;

	assign adv       = !vld_s[OUT_STG] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_s[OUT_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[OUT_STG-1:1], in_valid};
		end
	end

	// exp lanes: three scales and the opacity logit
	logic signed [15:0] ex_in [LANES];
	logic [MAG_W-1:0]   amag_s [LANES][1:EXP_DONE];
	logic               aneg_s [LANES][1:EXP_DONE];

	always_comb begin
		ex_in[0] = log_scale_x;
		ex_in[1] = log_scale_y;
		ex_in[2] = log_scale_z;
		ex_in[3] = opacity_logit;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				amag_s[l][1] <= ex_in[l][15] ? MAG_W'(~ex_in[l] + 16'sd1) : MAG_W'(ex_in[l]);
				aneg_s[l][1] <= ex_in[l][15];
				for (int j = 2; j <= EXP_DONE; j++) begin
					amag_s[l][j] <= amag_s[l][j-1];
					aneg_s[l][j] <= aneg_s[l][j-1];
				end
			end
		end
	end

	logic [PROD_W-1:0] tp_s  [1:TERMS][LANES];
	logic [SUM_W-1:0]  tsa_s [1:TERMS][LANES];
	logic [SUM_W-1:0]  tsb_s [1:TERMS][LANES];
	logic [SUM_W-1:0]  tsc_s [1:TERMS][LANES];
	logic [PP_W-1:0]   hh_s  [1:TERMS][LANES];
	logic [PP_W-1:0]   hl_s  [1:TERMS][LANES];
	logic [PP_W-1:0]   lh_s  [1:TERMS][LANES];
	logic [PP_W-1:0]   ll_s  [1:TERMS][LANES];
	logic [TERM_W-1:0] tt_s  [1:TERMS][LANES];

	for (genvar k = 1; k <= TERMS; k++) begin : g_term
		localparam logic [63:0] KDIV = 64'(k);
		localparam logic [63:0] RCP = ((64'd1 << RCP_SHIFT) + KDIV - 64'd1) / KDIV;
		localparam logic [24:0] RCP_HI = RCP[50:26];
		localparam logic [25:0] RCP_LO = RCP[25:0];
		localparam int JA = 3 * k - 1;

		logic [TERM_W-1:0] t_prev [LANES];
		logic [SUM_W-1:0]  s_prev [LANES];
		logic [XQ_W-1:0]   xq     [LANES];
		logic [FULL_W-1:0] full   [LANES];

		if (k == 1) begin : g_seed
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					t_prev[l] = TERM_W'(1) << 32;
					s_prev[l] = '0;
				end
			end
		end else begin : g_link
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					t_prev[l] = tt_s[k-1][l];
					s_prev[l] = tsc_s[k-1][l];
				end
			end
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				xq[l]   = tp_s[k][l][XQ_W+11:12];
				full[l] = (FULL_W'(hh_s[k][l]) << 48) + (FULL_W'(hl_s[k][l]) << 22) +
					(FULL_W'(lh_s[k][l]) << 26) + FULL_W'(ll_s[k][l]);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < LANES; l++) begin
					tp_s[k][l]  <= PROD_W'(t_prev[l]) * PROD_W'(amag_s[l][JA-1]);
					tsa_s[k][l] <= s_prev[l] + SUM_W'(t_prev[l]);
					hh_s[k][l]  <= PP_W'(xq[l][XQ_W-1:HALF_W]) * PP_W'(RCP_HI);
					hl_s[k][l]  <= PP_W'(xq[l][XQ_W-1:HALF_W]) * PP_W'(RCP_LO);
					lh_s[k][l]  <= PP_W'(xq[l][HALF_W-1:0]) * PP_W'(RCP_HI);
					ll_s[k][l]  <= PP_W'(xq[l][HALF_W-1:0]) * PP_W'(RCP_LO);
					tsb_s[k][l] <= tsa_s[k][l];
					tt_s[k][l]  <= full[l][RCP_SHIFT+TERM_W-1:RCP_SHIFT];
					tsc_s[k][l] <= tsb_s[k][l];
				end
			end
		end
	end

	logic [SUM_W-1:0] e_s [LANES];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				e_s[l] <= tsc_s[TERMS][l] + SUM_W'(tt_s[TERMS][l]);
			end
		end
	end

	// divider: scale reciprocal and sigmoid quotient
	logic [NUM_W-1:0] dp_num [LANES];
	logic [DEN_W-1:0] dp_den [LANES];
	logic [31:0]      dp_dir [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			dp_dir[l] = 32'((DEN_W'(e_s[l]) + (DEN_W'(1) << 15)) >> 16);
			if (l == LANES - 1) begin
				dp_den[l] = DEN_W'(e_s[l]) + (DEN_W'(1) << 32);
				dp_num[l] = aneg_s[l][EXP_DONE] ?
					(NUM_W'(1) << 48) + NUM_W'(dp_den[l] >> 1) :
					(NUM_W'(e_s[l]) << 16) + NUM_W'(dp_den[l] >> 1);
			end else begin
				dp_den[l] = DEN_W'(e_s[l]);
				dp_num[l] = (NUM_W'(1) << 48) + NUM_W'(e_s[l] >> 1);
			end
		end
	end

	logic [NUM_W-1:0] dv_rem_s [0:QB][LANES];
	logic [DEN_W-1:0] dv_den_s [0:QB][LANES];
	logic [QB-1:0]    dv_quo_s [0:QB][LANES];
	logic [31:0]      dv_dir_s [0:QB][LANES];
	logic             dv_neg_s [0:QB][LANES];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < LANES; l++) begin
				dv_rem_s[0][l] <= dp_num[l];
				dv_den_s[0][l] <= dp_den[l];
				dv_quo_s[0][l] <= '0;
				dv_dir_s[0][l] <= dp_dir[l];
				dv_neg_s[0][l] <= aneg_s[l][EXP_DONE];
			end
		end
	end

	for (genvar t = 1; t <= QB; t++) begin : g_div
		logic [DCMP_W-1:0] sh [LANES];
		logic              ge [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				sh[l] = DCMP_W'(dv_den_s[t-1][l]) << (QB - t);
				ge[l] = DCMP_W'(dv_rem_s[t-1][l]) >= sh[l];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < LANES; l++) begin
					dv_rem_s[t][l] <= ge[l] ? dv_rem_s[t-1][l] - sh[l][NUM_W-1:0] :
						dv_rem_s[t-1][l];
					dv_quo_s[t][l] <= {dv_quo_s[t-1][l][QB-2:0], ge[l]};
					dv_den_s[t][l] <= dv_den_s[t-1][l];
					dv_dir_s[t][l] <= dv_dir_s[t-1][l];
					dv_neg_s[t][l] <= dv_neg_s[t-1][l];
				end
			end
		end
	end

	// rotation: sum of squares, square root, four dividers
	logic signed [15:0] q_in [4];
	logic [SQ_W-1:0]    sq_s1;
	rot_side_t          rs_s [1:ROT_DONE-1];

	always_comb begin
		q_in[0] = rot_w;
		q_in[1] = rot_x;
		q_in[2] = rot_y;
		q_in[3] = rot_z;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s1 <= SQ_W'(32'(rot_w * rot_w)) + SQ_W'(32'(rot_x * rot_x)) +
				SQ_W'(32'(rot_y * rot_y)) + SQ_W'(32'(rot_z * rot_z));
			for (int c = 0; c < 4; c++) begin
				rs_s[1].neg[c] <= q_in[c][15];
				rs_s[1].mag[c] <= q_in[c][15] ? 16'(~q_in[c] + 16'sd1) : 16'(q_in[c]);
			end
			rs_s[1].dflt <= (rot_w == 16'sd0) && (rot_x == 16'sd0) &&
				(rot_y == 16'sd0) && (rot_z == 16'sd0);
			for (int j = 2; j < ROT_DONE; j++) begin
				rs_s[j] <= rs_s[j-1];
			end
		end
	end

	logic [SRM_W-1:0] sr_rem_s  [1:RT_W];
	logic [RT_W-1:0]  sr_root_s [1:RT_W];

	for (genvar u = 1; u <= RT_W; u++) begin : g_sqrt
		localparam int B = RT_W - u;
		logic [SRM_W-1:0] rem_i;
		logic [SRM_W-1:0] trial;
		logic [RT_W-1:0]  root_i;
		logic             ge;

		if (u == 1) begin : g_seed
			assign rem_i  = SRM_W'(sq_s1) << 16;
			assign root_i = '0;
		end else begin : g_link
			assign rem_i  = sr_rem_s[u-1];
			assign root_i = sr_root_s[u-1];
		end

		assign trial = (SRM_W'(root_i) << (B + 1)) + (SRM_W'(1) << (2 * B));
		assign ge    = rem_i >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				sr_rem_s[u]  <= ge ? rem_i - trial : rem_i;
				sr_root_s[u] <= ge ? (root_i | (RT_W'(1) << B)) : root_i;
			end
		end
	end

	logic [RNUM_W-1:0] rd_rem_s [0:RQB][4];
	logic [RQB-1:0]    rd_quo_s [0:RQB][4];
	logic [RT_W-1:0]   rd_den_s [0:RQB];

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_den_s[0] <= sr_root_s[RT_W];
			for (int c = 0; c < 4; c++) begin
				rd_rem_s[0][c] <= (RNUM_W'(rs_s[RDIV_PREP-1].mag[c]) << 22) +
					RNUM_W'(sr_root_s[RT_W] >> 1);
				rd_quo_s[0][c] <= '0;
			end
		end
	end

	for (genvar t = 1; t <= RQB; t++) begin : g_rdiv
		logic [RCMP_W-1:0] sh;
		logic              ge [4];

		assign sh = RCMP_W'(rd_den_s[t-1]) << (RQB - t);

		always_comb begin
			for (int c = 0; c < 4; c++) begin
				ge[c] = RCMP_W'(rd_rem_s[t-1][c]) >= sh;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rd_den_s[t] <= rd_den_s[t-1];
				for (int c = 0; c < 4; c++) begin
					rd_rem_s[t][c] <= ge[c] ? rd_rem_s[t-1][c] - sh[RNUM_W-1:0] :
						rd_rem_s[t-1][c];
					rd_quo_s[t][c] <= {rd_quo_s[t-1][c][RQB-2:0], ge[c]};
				end
			end
		end
	end

	logic [14:0]        rq [4];
	logic signed [15:0] rv [4];
	rot_res_t           rot_fin;
	rot_res_t           rr_s [ROT_DONE:OUT_STG-1];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			rq[c] = (rd_quo_s[RQB][c] > ONE_Q14) ? ONE_Q14 : rd_quo_s[RQB][c];
			rv[c] = (rs_s[ROT_DONE-1].neg[c] ^ rs_s[ROT_DONE-1].neg[0]) ?
				-$signed(16'(rq[c])) : $signed(16'(rq[c]));
		end
		if (rs_s[ROT_DONE-1].dflt) begin
			rot_fin.w = ONE_Q14;
			rot_fin.x = '0;
			rot_fin.y = '0;
			rot_fin.z = '0;
		end else begin
			rot_fin.w = rq[0];
			rot_fin.x = rv[1];
			rot_fin.y = rv[2];
			rot_fin.z = rv[3];
		end
		rot_fin.dflt = rs_s[ROT_DONE-1].dflt;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rr_s[ROT_DONE] <= rot_fin;
			for (int j = ROT_DONE + 1; j < OUT_STG; j++) begin
				rr_s[j] <= rr_s[j-1];
			end
		end
	end

	// colour
	logic signed [15:0] dc_in  [3];
	logic signed [40:0] cp_s1  [3];
	logic signed [40:0] c_rnd  [3];
	logic signed [17:0] c_val  [3];
	logic [2:0][15:0]   c_sat;
	logic [2:0][15:0]   cl_s   [2:OUT_STG-1];

	always_comb begin
		dc_in[0] = dc_red;
		dc_in[1] = dc_green;
		dc_in[2] = dc_blue;
		for (int c = 0; c < 3; c++) begin
			c_rnd[c] = cp_s1[c] + 41'sd8388608;
			c_val[c] = 18'(c_rnd[c] >>> 24) + 18'sd2048;
			if (c_val[c] > 18'sd32767) begin
				c_sat[c] = 16'h7FFF;
			end else if (c_val[c] < -18'sd32768) begin
				c_sat[c] = 16'h8000;
			end else begin
				c_sat[c] = c_val[c][15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				cp_s1[c] <= 41'(dc_in[c]) * 41'(C0_Q24);
			end
			cl_s[2] <= c_sat;
			for (int j = 3; j < OUT_STG; j++) begin
				cl_s[j] <= cl_s[j-1];
			end
		end
	end

	// output register
	logic [31:0] scl [3];
	logic [15:0] alp;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			scl[l] = dv_neg_s[QB][l] ? 32'(dv_quo_s[QB][l]) : dv_dir_s[QB][l];
		end
		alp = (dv_quo_s[QB][LANES-1] > 17'd65535) ? 16'hFFFF : dv_quo_s[QB][LANES-1][15:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			unit_w             <= rr_s[OUT_STG-1].w;
			unit_x             <= rr_s[OUT_STG-1].x;
			unit_y             <= rr_s[OUT_STG-1].y;
			unit_z             <= rr_s[OUT_STG-1].z;
			rotation_defaulted <= rr_s[OUT_STG-1].dflt;
			scale_x            <= scl[0];
			scale_y            <= scl[1];
			scale_z            <= scl[2];
			alpha              <= alp;
			color_red          <= $signed(cl_s[OUT_STG-1][0]);
			color_green        <= $signed(cl_s[OUT_STG-1][1]);
			color_blue         <= $signed(cl_s[OUT_STG-1][2]);
		end
	end

	logic rot_ident;

	assign rot_ident = (unit_w == ONE_Q14) && (unit_x == 16'sd0) && (unit_y == 16'sd0) &&
		(unit_z == 16'sd0);

	`SAD_ASSERT_IMP(a_default_identity, out_valid && rotation_defaulted, rot_ident, "not identity")
	`SAD_ASSERT_IMP(a_unit_w_range, out_valid, unit_w <= ONE_Q14, "unit_w above one")
	`SAD_ASSERT_IMP(a_unit_x_range, out_valid, unit_x <= 16'sd16384 && unit_x >= -16'sd16384, "unit_x out of range")
	`SAD_ASSERT_NXT(a_stall_freeze, in_stall, $stable(vld_s), "pipeline moved while stalled")

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splat attribute decoder testbench
// Drives splat records through the decoder with random bursts and output
// stalls. An in-bench fixed-point model predicts each decoded record; a
// scoreboard checks every output field in order.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [15:0] rot[4];
		logic signed [15:0] lsc[3];
		logic signed [15:0] dc[3];
		logic signed [15:0] opa;
	} splat_raw_t;

	typedef struct {
		logic [14:0]        w;
		logic signed [15:0] x, y, z;
		logic [31:0]        sc[3];
		logic signed [15:0] col[3];
		logic [15:0]        alpha;
		logic               dflt;
	} splat_dec_t;

	function automatic logic [63:0] exp_series(int unsigned a);
		logic [63:0] acc, term;
		acc = 64'd1 << 32;
		term = acc;
		for (int k = 1; k < 64; k++) begin
			term = (term * a) / (64'd4096 * k);
			acc += term;
		end
		return acc;
	endfunction

	function automatic logic [31:0] scale_of(logic signed [15:0] v);
		logic [63:0] e, r;
		int a;
		a = (v < 0) ? -int'(v) : int'(v);
		e = exp_series(a);
		if (v >= 0)
			r = (e + (64'd1 << 15)) >> 16;
		else
			r = ((64'd1 << 48) + (e >> 1)) / e;
		if (r > 64'hFFFFFFFF)
			r = 64'hFFFFFFFF;
		return r[31:0];
	endfunction

	function automatic logic [15:0] alpha_of(logic signed [15:0] v);
		logic [63:0] e, d, r;
		int a;
		a = (v < 0) ? -int'(v) : int'(v);
		e = exp_series(a);
		d = e + (64'd1 << 32);
		if (v >= 0)
			r = ((e << 16) + (d >> 1)) / d;
		else
			r = ((64'd1 << 48) + (d >> 1)) / d;
		if (r > 65535)
			r = 65535;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] color_of(logic signed [15:0] dc);
		longint p, q;
		p = longint'(dc) * 64'sd4732765 + (64'sd1 << 23);
		q = (p >>> 24) + 2048;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] s);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s)
			b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else
				res >>= 1;
			b >>= 2;
		end
		return res;
	endfunction

	function automatic splat_dec_t decode_splat(splat_raw_t s);
		splat_dec_t d;
		logic [63:0] sum, n, m, r;
		int u[4];
		sum = 0;
		for (int i = 0; i < 4; i++)
			sum += longint'(s.rot[i]) * longint'(s.rot[i]);
		d.dflt = (sum == 0);
		if (d.dflt) begin
			u = '{16384, 0, 0, 0};
		end else begin
			n = isqrt(sum << 16);
			for (int i = 0; i < 4; i++) begin
				m = (s.rot[i] < 0) ? -longint'(s.rot[i]) : longint'(s.rot[i]);
				r = ((m << 22) + (n >> 1)) / n;
				if (r > 16384)
					r = 16384;
				u[i] = (s.rot[i] < 0) ? -int'(r) : int'(r);
			end
			if (s.rot[0] < 0)
				for (int i = 0; i < 4; i++)
					u[i] = -u[i];
		end
		d.w = u[0][14:0];
		d.x = u[1][15:0];
		d.y = u[2][15:0];
		d.z = u[3][15:0];
		for (int i = 0; i < 3; i++) begin
			d.sc[i] = scale_of(s.lsc[i]);
			d.col[i] = color_of(s.dc[i]);
		end
		d.alpha = alpha_of(s.opa);
		return d;
	endfunction

	class splat_scoreboard;
		splat_dec_t pending[$];
		int errors;

		function void note_input(splat_raw_t s);
			pending.insert(pending.size(), decode_splat(s));
		endfunction

		function void cmp(string f, longint e, longint a);
			if (e != a) begin
				$error("%s expected %0d actual %0d", f, e, a);
				errors++;
			end
		endfunction

		function void check_result(splat_dec_t a);
			splat_dec_t e;
			if (pending.size() == 0) begin
				$error("unexpected output item");
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("unit_w", e.w, a.w);
			cmp("unit_x", e.x, a.x);
			cmp("unit_y", e.y, a.y);
			cmp("unit_z", e.z, a.z);
			cmp("scale_x", e.sc[0], a.sc[0]);
			cmp("scale_y", e.sc[1], a.sc[1]);
			cmp("scale_z", e.sc[2], a.sc[2]);
			cmp("color_red", e.col[0], a.col[0]);
			cmp("color_green", e.col[1], a.col[1]);
			cmp("color_blue", e.col[2], a.col[2]);
			cmp("alpha", e.alpha, a.alpha);
			cmp("rotation_defaulted", e.dflt, a.dflt);
		endfunction
	endclass

	logic clk = 0, arst_n = 0, in_valid = 0, out_stall = 0;
	logic in_stall, out_valid;
	logic signed [15:0] rot_w = 0, rot_x = 0, rot_y = 0, rot_z = 0;
	logic signed [15:0] log_scale_x = 0, log_scale_y = 0, log_scale_z = 0;
	logic signed [15:0] dc_red = 0, dc_green = 0, dc_blue = 0, opacity_logit = 0;
	logic [14:0] unit_w;
	logic signed [15:0] unit_x, unit_y, unit_z, color_red, color_green, color_blue;
	logic [31:0] scale_x, scale_y, scale_z;
	logic [15:0] alpha;
	logic rotation_defaulted;
	splat_scoreboard board = new();
	longint cycles = 0;
	bit stim_done = 0;

	splat_attribute_decoder dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("tb failed");
			$finish;
		end
	end

	task automatic send_splat(splat_raw_t s);
		in_valid <= 1;
		{rot_w, rot_x, rot_y, rot_z} <= {s.rot[0], s.rot[1], s.rot[2], s.rot[3]};
		{log_scale_x, log_scale_y, log_scale_z} <= {s.lsc[0], s.lsc[1], s.lsc[2]};
		{dc_red, dc_green, dc_blue} <= {s.dc[0], s.dc[1], s.dc[2]};
		opacity_logit <= s.opa;
		do @(posedge clk); while (in_stall);
		board.note_input(s);
	endtask

	function automatic logic signed [15:0] pick();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 200) - 100);
			3: return 16'($urandom_range(0, 32767));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic splat_raw_t random_splat();
		splat_raw_t s;
		for (int i = 0; i < 4; i++)
			s.rot[i] = ($urandom_range(0, 20) == 0) ? 16'sd0 : pick();
		if ($urandom_range(0, 30) == 0)
			s.rot = '{0, 0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			s.lsc[i] = pick();
			s.dc[i] = pick();
		end
		s.opa = pick();
		return s;
	endfunction

	function automatic splat_raw_t fill_splat(logic signed [15:0] v);
		splat_raw_t s;
		s.rot = '{v, v, v, v};
		s.lsc = '{v, v, v};
		s.dc = '{v, v, v};
		s.opa = v;
		return s;
	endfunction

	initial begin
		splat_raw_t s;
		int gap;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_splat(fill_splat(16'sd0));
		send_splat(fill_splat(16'sh7FFF));
		send_splat(fill_splat(16'sh8000));
		send_splat(fill_splat(16'sd1));
		send_splat(fill_splat(-16'sd1));
		s = fill_splat(16'sd4096);
		s.rot = '{-16'sd1, 16'sd0, 16'sd0, 16'sd0};
		send_splat(s);
		s.rot = '{-16'sd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
		send_splat(s);
		s.rot = '{16'sd0, 16'sd0, 16'sd0, 16'sh8000};
		send_splat(s);
		s.rot = '{16'sh8000, 16'sd3, -16'sd3, 16'sd0};
		send_splat(s);
		for (int n = 0; n < 1350;) begin
			for (int b = $urandom_range(1, 40); b > 0 && n < 1350; b--, n++)
				send_splat(random_splat());
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 0;
		stim_done = 1;
	end

	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			phase++;
			if (phase % 600 < 150)
				out_stall <= 0;
			else
				out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		splat_dec_t a;
		if (arst_n && out_valid && !out_stall) begin
			a.w = unit_w;
			a.x = unit_x;
			a.y = unit_y;
			a.z = unit_z;
			a.sc = '{scale_x, scale_y, scale_z};
			a.col = '{color_red, color_green, color_blue};
			a.alpha = alpha;
			a.dflt = rotation_defaulted;
			board.check_result(a);
		end
	end

	initial begin
		wait (stim_done);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
